### sv/vdi_pkg.sv
// Shared constants and key helpers for the vertex dedup indexer.
`default_nettype none
package vdi_pkg;
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_W = 32;
   localparam int KEY_W = 3 * COORD_W;
   localparam int IDX_W = 10;
   localparam int CORNER_W = 2;
   localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd2;

   typedef logic [KEY_W-1:0] key_type;

   function automatic logic [COORD_W-1:0] canon_coord(input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] r;
      r = b;
      if (b[COORD_W-2:0] == '0) begin
         r = '0;
      end
      return r;
   endfunction

   function automatic key_type canon_key(input key_type k);
      key_type r;
      r = {canon_coord(k[3*COORD_W-1:2*COORD_W]),
           canon_coord(k[2*COORD_W-1:COORD_W]),
           canon_coord(k[COORD_W-1:0])};
      return r;
   endfunction
endpackage
`default_nettype wire

### sv/vdi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### sv/vertex_dedup_indexer.sv
// A req beat is accepted only in the idle state, so one vertex is processed at a time;
// the rsp beat also waits while the previous rsp beat is held by rsp_tready.
// Lookup is a linear scan of the key RAM, one entry read per cycle through its single
// read port, until a hit or the end of the stored vertices (count = stored vertices).
// Reset clears the vertex count, corner counter and handshake state; the
// key RAM is not cleared, entries at or above the count are never compared.
`default_nettype none
module vertex_dedup_indexer import vdi_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,  // x_bits, y_bits, z_bits
   input  wire logic        req_tuser,  // start_mesh
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // vertex_index, is_new, table_full, corner, zero pad
   output logic             rsp_tlast   // triangle_done
);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

   typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic [CORNER_W-1:0] cur_corner_ff, cur_corner_in;
   key_type             key_ff, key_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       chk_ff, chk_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                hold_ff, hold_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                new_ff, new_in;
   logic                full_ff, full_in;
   logic [CORNER_W-1:0] ocorner_ff, ocorner_in;

   key_type rdata;
   logic    we;
   logic    hit;
   logic    slot_free;
   logic    req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign hit = chk_vld_ff && (hold_ff || (rdata == key_ff));
   assign slot_free = !rsp_vld_ff || rsp_tready;
   assign we = (state_ff == ST_SCAN) && slot_free && !hit && (ptr_ff == count_ff)
               && (count_ff != MAX_CNT);

   vdi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_VERTICES)) u_keys (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[AW-1:0]),
      .wdata (key_ff),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (rdata)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      corner_in = corner_ff;
      cur_corner_in = cur_corner_ff;
      key_in = key_ff;
      ptr_in = ptr_ff;
      chk_in = chk_ff;
      chk_vld_in = chk_vld_ff;
      hold_in = hold_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      idx_in = idx_ff;
      new_in = new_ff;
      full_in = full_ff;
      ocorner_in = ocorner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               logic [CORNER_W-1:0] c;
               c = req_tuser ? '0 : corner_ff;
               if (req_tuser) begin
                  count_in = '0;
               end
               cur_corner_in = c;
               corner_in = (c == CORNER_LAST) ? '0 : c + 1'b1;
               key_in = canon_key(req_tdata);
               ptr_in = '0;
               chk_vld_in = 1'b0;
               hold_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || ptr_ff == count_ff) begin
               if (slot_free) begin
                  rsp_vld_in = 1'b1;
                  ocorner_in = cur_corner_ff;
                  state_in = ST_IDLE;
                  if (hit) begin
                     idx_in = IDX_W'(chk_ff);
                     new_in = 1'b0;
                     full_in = 1'b0;
                  end else if (count_ff != MAX_CNT) begin
                     idx_in = IDX_W'(count_ff);
                     new_in = 1'b1;
                     full_in = 1'b0;
                     count_in = count_ff + 1'b1;
                  end else begin
                     idx_in = '0;
                     new_in = 1'b0;
                     full_in = 1'b1;
                  end
               end else begin
                  hold_in = hit;
                  chk_vld_in = hit;
               end
            end else begin
               chk_in = ptr_ff;
               chk_vld_in = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         corner_ff <= '0;
         rsp_vld_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         corner_ff <= corner_in;
         rsp_vld_ff <= rsp_vld_in;
         chk_vld_ff <= chk_vld_in;
         hold_ff <= hold_in;
      end
      cur_corner_ff <= cur_corner_in;
      key_ff <= key_in;
      ptr_ff <= ptr_in;
      chk_ff <= chk_in;
      idx_ff <= idx_in;
      new_ff <= new_in;
      full_ff <= full_in;
      ocorner_ff <= ocorner_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = {2'b00, ocorner_ff, full_ff, new_ff, idx_ff};
   assign rsp_tlast = (ocorner_ff == CORNER_LAST);
endmodule
`default_nettype wire

### sv/vdi_checker.sv
// Port-level checks for the vertex dedup indexer, bound to the top level.
`default_nettype none
module vdi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[13:12] == 2'd2)))
      else $error("tlast disagrees with corner");
   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:12] != 2'd3))
      else $error("corner out of range");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[11]) |-> (rsp_tdata[9:0] == 10'd0 && !rsp_tdata[10]))
      else $error("full beat carries index or new flag");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");
   a_no_result_early: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !(rsp_tvalid && !$past(rsp_tvalid)))
      else $error("result appeared one cycle after accept");
endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
